// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, expr, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) else $error(msg);
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, expr, msg)
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

// File: rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Sizes, codes and the interface types between the top level and its ALU.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int DEPTH  = 16;
    localparam int WIDTH  = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = $clog2(WIDTH);

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;
    localparam int M_PAD_W   = M_TDATA_W - WIDTH - CNT_W;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_OPER = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } alu_op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_FEW  = 2'd2,
        ST_DIV0 = 2'd3
    } status_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] result;
    } alu_rsp_t;

endpackage

// File: rtl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// RPN stack calculator
// A push or a refused operator goes from S_IDLE to S_DONE; an accepted operator
// passes S_READ and S_EXEC first, and multiply and divide hold S_EXEC on the
// shared ALU, which works one bit per cycle; items are taken only in S_IDLE.
// The stack lives in a synchronous RAM of DEPTH words; the top entry is also
// kept in a register, so an operator reads only the entry below it. The RAM
// needs no clearing after reset: entries are read only below the fill count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpn_stack_calculator
    import rsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] operand
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] func, [2:1] alu_op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] top_value, [36:32] depth, zero pad
    output logic [M_TUSER_W-1:0] m_tuser    // [1:0] status
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [WIDTH-1:0] top_reg, top_next;
    alu_op_t          op_reg, op_next;
    status_t          status_reg, status_next;

    logic             out_valid_reg;
    logic [WIDTH-1:0] out_top_reg;
    logic [CNT_W-1:0] out_depth_reg;
    status_t          out_status_reg;
    logic             out_load;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [WIDTH-1:0] mem_wdata;
    logic [PTR_W-1:0] mem_raddr;
    logic [CNT_W-1:0] below_top;

    alu_req_t         alu_req;
    alu_rsp_t         alu_rsp;
    alu_op_t          in_op;

    rsc_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (rd_data_reg),
        .b     (top_reg),
        .rsp   (alu_rsp)
    );

    assign below_top = count_reg - CNT_W'(2);
    assign mem_raddr = below_top[PTR_W-1:0];
    assign in_op     = alu_op_t'(s_tuser[2:1]);
    assign s_tready  = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        top_next      = top_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[PTR_W-1:0];
        mem_wdata     = s_tdata[WIDTH-1:0];
        alu_req.start = 1'b0;
        alu_req.op    = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DONE;
                    if (s_tuser[0] == FUNC_PUSH)
                    begin
                        if (count_reg >= CNT_W'(DEPTH))
                            status_next = ST_FULL;
                        else
                        begin
                            mem_we      = 1'b1;
                            top_next    = s_tdata[WIDTH-1:0];
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_OK;
                        end
                    end
                    else if (count_reg < CNT_W'(2))
                        status_next = ST_FEW;
                    else if (in_op == OP_DIV && top_reg == '0)
                        status_next = ST_DIV0;
                    else
                    begin
                        op_next    = in_op;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                // The entry below the top arrived from the RAM this cycle.
                alu_req.start = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = below_top[PTR_W-1:0];
                    mem_wdata   = alu_rsp.result;
                    top_next    = alu_rsp.result;
                    count_next  = count_reg - CNT_W'(1);
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        op_reg     <= op_next;
        status_reg <= status_next;
        if (out_load)
        begin
            out_top_reg    <= (count_reg == '0) ? '0 : top_reg;
            out_depth_reg  <= count_reg;
            out_status_reg <= status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_depth_reg, out_top_reg};
    assign m_tuser  = out_status_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "stack count above depth")
    `ASSERT_IMPLIES(a_alu_start, clk, rst_n, alu_req.start, state_reg == S_READ, "ALU started outside read")
    `ASSERT_IMPLIES(a_alu_done, clk, rst_n, alu_rsp.done, state_reg == S_EXEC, "ALU result with no operator waiting")
    `ASSERT_IMPLIES(a_out_source, clk, rst_n, $rose(m_tvalid), $past(state_reg == S_DONE), "result beat without a finished item")

endmodule

// File: rtl/rsc_alu.sv
// ----------------------------------------------------------------------------
// RPN calculator ALU
// Registered add and subtract, bit-serial shift-add multiply and restoring
// divide, one bit per cycle.
// ----------------------------------------------------------------------------
module rsc_alu
    import rsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  alu_req_t         req,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output alu_rsp_t         rsp
);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_MUL  = 3'b010,
        A_DIV  = 3'b100
    } alu_state_t;

    alu_state_t        state_reg;
    logic              done_reg;
    logic [WIDTH-1:0]  result_reg;
    logic [WIDTH-1:0]  acc_reg;
    logic [WIDTH-1:0]  x_reg;
    logic [WIDTH-1:0]  y_reg;
    logic [STEP_W-1:0] step_reg;

    logic [WIDTH-1:0]  mul_acc_next;
    logic [WIDTH:0]    div_trial;
    logic [WIDTH:0]    div_diff;
    logic              div_fits;
    logic [WIDTH-1:0]  rem_next;
    logic [WIDTH-1:0]  quo_next;
    logic              last_step;

    always_comb
    begin
        mul_acc_next = acc_reg + (y_reg[0] ? x_reg : '0);
        // The partial remainder stays below the divisor, so the trial word
        // needs only one bit more than a data word.
        div_trial = {acc_reg, x_reg[WIDTH-1]};
        div_diff  = div_trial - {1'b0, y_reg};
        div_fits  = (div_trial >= {1'b0, y_reg});
        rem_next  = div_fits ? div_diff[WIDTH-1:0] : div_trial[WIDTH-1:0];
        quo_next  = {x_reg[WIDTH-2:0], div_fits};
        last_step = (step_reg == STEP_W'(WIDTH - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        case (req.op)
                            OP_MUL:  state_reg <= A_MUL;
                            OP_DIV:  state_reg <= A_DIV;
                            default: done_reg  <= 1'b1;
                        endcase
                    end
                end
                A_MUL, A_DIV:
                begin
                    if (last_step)
                    begin
                        state_reg <= A_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == A_IDLE && req.start)
        begin
            acc_reg  <= '0;
            x_reg    <= a;
            y_reg    <= b;
            step_reg <= '0;
            case (req.op)
                OP_ADD:  result_reg <= a + b;
                OP_SUB:  result_reg <= a - b;
                default: result_reg <= result_reg;
            endcase
        end
        else if (state_reg == A_MUL)
        begin
            acc_reg  <= mul_acc_next;
            x_reg    <= {x_reg[WIDTH-2:0], 1'b0};
            y_reg    <= {1'b0, y_reg[WIDTH-1:1]};
            step_reg <= step_reg + STEP_W'(1);
            if (last_step)
                result_reg <= mul_acc_next;
        end
        else if (state_reg == A_DIV)
        begin
            acc_reg  <= rem_next;
            x_reg    <= quo_next;
            step_reg <= step_reg + STEP_W'(1);
            if (last_step)
                result_reg <= quo_next;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule
